[hw/rtl/ssbm_pkg.sv]
`timescale 1ns / 1ps

package ssbm_pkg;

  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int MIX_W      = 17;
  localparam int COEF_W     = 25;
  localparam int SHAPE_W    = 16;
  localparam int CLAMP_W    = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIX        = 3'd0,
    CFG_LOW_COEF   = 3'd1,
    CFG_LOW_DECAY  = 3'd2,
    CFG_HIGH_COEF  = 3'd3,
    CFG_HIGH_DECAY = 3'd4,
    CFG_PRE_SHAPE  = 3'd5,
    CFG_POST_SHAPE = 3'd6,
    CFG_CLAMP      = 3'd7
  } cfg_idx_t;

  localparam logic [MIX_W-1:0]   MIX_RESET        = 17'd26214;
  localparam logic [COEF_W-1:0]  LOW_COEF_RESET   = 25'd1048576;
  localparam logic [COEF_W-1:0]  LOW_DECAY_RESET  = 25'd16000000;
  localparam logic [COEF_W-1:0]  HIGH_COEF_RESET  = 25'd524288;
  localparam logic [COEF_W-1:0]  HIGH_DECAY_RESET = 25'd16700000;
  localparam logic [SHAPE_W-1:0] PRE_SHAPE_RESET  = 16'd8192;
  localparam logic [SHAPE_W-1:0] POST_SHAPE_RESET = 16'd4096;
  localparam logic [CLAMP_W-1:0] CLAMP_RESET      = 23'd8388607;

  localparam logic [COEF_W-1:0] COEF_ONE  = 25'h1000000;
  localparam logic [MIX_W-1:0]  MIX_ONE   = 17'h10000;
  localparam logic [MIX_W-1:0]  MIX_HALF  = 17'h08000;
  localparam logic [14:0]       DC_POLE   = 15'd32604;
  localparam logic [COEF_W-1:0] SHAPE_ONE = 25'd4096;

  // Datapath micro-steps
  typedef enum logic [3:0] {
    P_K_MAG    = 4'd0,
    P_DEN      = 4'd1,
    P_DIV_LOAD = 4'd2,
    P_DIV      = 4'd3,
    P_CLIP_END = 4'd4,
    P_SEC_MA   = 4'd5,
    P_SEC_MB   = 4'd6,
    P_SEC_UA   = 4'd7,
    P_SEC_MC   = 4'd8,
    P_SEC_MD   = 4'd9,
    P_SEC_UB   = 4'd10,
    P_DC_M     = 4'd11,
    P_DC_END   = 4'd12,
    P_MIX_M    = 4'd13,
    P_MIX_END  = 4'd14
  } step_t;

  typedef struct packed {
    logic  start;     // latch a new input word
    logic  out_load;  // load the result register
    logic  sel;       // first/second clipper and filter section
    step_t step;
  } cmd_t;

endpackage

[hw/rtl/ssbm_if.sv]
`timescale 1ns / 1ps

interface ssbm_in_if #(parameter int SAMPLE_BITS = ssbm_pkg::SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  modport source (output valid, sample_in, input ready);
  modport sink   (input valid, sample_in, output ready);
endinterface

interface ssbm_out_if #(parameter int SAMPLE_BITS = ssbm_pkg::SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

interface ssbm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ssbm_pkg::CFG_IDX_W-1:0]   index;
  logic [ssbm_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/ssbm_ctrl.sv]
`timescale 1ns / 1ps

module ssbm_ctrl #(
  parameter int SAMPLE_BITS = ssbm_pkg::SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output ssbm_pkg::cmd_t   cmd
);

  localparam int QW  = SAMPLE_BITS + 5;
  localparam int CW  = $clog2(QW);
  localparam logic [CW-1:0] CNT_LAST = CW'(QW - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DIV  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  ssbm_pkg::step_t       step_r, step_nxt;
  logic                  sel_r, sel_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.start     = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.sel       = sel_r;
    cmd.step      = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_CALC;
          step_nxt  = ssbm_pkg::P_K_MAG;
          sel_nxt   = 1'b0;
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_CALC;
          step_nxt  = ssbm_pkg::P_CLIP_END;
        end
      end
      ST_CALC: begin
        case (step_r)
          ssbm_pkg::P_K_MAG:    step_nxt = ssbm_pkg::P_DEN;
          ssbm_pkg::P_DEN:      step_nxt = ssbm_pkg::P_DIV_LOAD;
          ssbm_pkg::P_DIV_LOAD: begin
            state_nxt = ST_DIV;
            step_nxt  = ssbm_pkg::P_DIV;
            cnt_nxt   = '0;
          end
          ssbm_pkg::P_CLIP_END: begin
            step_nxt = sel_r ? ssbm_pkg::P_DC_M : ssbm_pkg::P_SEC_MA;
          end
          ssbm_pkg::P_SEC_MA:   step_nxt = ssbm_pkg::P_SEC_MB;
          ssbm_pkg::P_SEC_MB:   step_nxt = ssbm_pkg::P_SEC_UA;
          ssbm_pkg::P_SEC_UA:   step_nxt = ssbm_pkg::P_SEC_MC;
          ssbm_pkg::P_SEC_MC:   step_nxt = ssbm_pkg::P_SEC_MD;
          ssbm_pkg::P_SEC_MD:   step_nxt = ssbm_pkg::P_SEC_UB;
          ssbm_pkg::P_SEC_UB: begin
            // lowpass section feeds highpass section, then the second clipper
            step_nxt = sel_r ? ssbm_pkg::P_K_MAG : ssbm_pkg::P_SEC_MA;
            sel_nxt  = 1'b1;
          end
          ssbm_pkg::P_DC_M:     step_nxt = ssbm_pkg::P_DC_END;
          ssbm_pkg::P_DC_END:   step_nxt = ssbm_pkg::P_MIX_M;
          ssbm_pkg::P_MIX_M:    step_nxt = ssbm_pkg::P_MIX_END;
          ssbm_pkg::P_MIX_END: begin
            // hold until the result register is free
            if (out_free) begin
              cmd.out_load  = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= ssbm_pkg::P_K_MAG;
      sel_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sel_r       <= sel_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/ssbm_datapath.sv]
`timescale 1ns / 1ps

module ssbm_datapath #(
  parameter int SAMPLE_BITS = ssbm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssbm_pkg::cmd_t                    cmd,
  input  logic                              cfg_we,
  input  logic [ssbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssbm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  output logic signed [SAMPLE_BITS-1:0]     out_sample
);

  localparam int SB  = SAMPLE_BITS;
  localparam int F   = SB - 1;
  localparam int QW  = SB + 5;   // quotient bits of the clipper divide
  localparam int DW  = 26;       // divisor / remainder bits
  localparam int MBW = 34;       // signed multiplier operand
  localparam int PW  = 60;       // product
  localparam int CW  = ssbm_pkg::COEF_W;
  localparam logic signed [63:0] SMAX64 = (64'sd1 <<< F) - 64'sd1;
  localparam logic signed [63:0] SMIN64 = -SMAX64 - 64'sd1;
  localparam logic signed [63:0] S32MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32MIN = -64'sd2147483648;
  localparam logic [DW-1:0]      DEN_ONE = DW'(1 << 20);

  function automatic logic signed [SB-1:0] sat_s(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v > SMAX64) ? SMAX64 : ((v < SMIN64) ? SMIN64 : v);
    return t[SB-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v > S32MAX) ? S32MAX : ((v < S32MIN) ? S32MIN : v);
    return t[31:0];
  endfunction

  // Configuration registers
  logic [ssbm_pkg::MIX_W-1:0]   mix_r;
  logic [CW-1:0]                lc_r, ld_r, hc_r, hd_r;
  logic [ssbm_pkg::SHAPE_W-1:0] k1_r, k2_r;
  logic [ssbm_pkg::CLAMP_W-1:0] clamp_r;

  // Filter state
  logic signed [31:0]    band0_r, low0_r, band1_r, low1_r;
  logic signed [SB-1:0]  dc_in_r, dc_out_r;

  // Working registers
  logic signed [SB-1:0]  dry_r, cur_r, out_r;
  logic signed [PW-1:0]  prod_r, acc_r;
  logic [DW-1:0]         den_r, rem_r;
  logic [QW-1:0]         quo_r;

  logic [ssbm_pkg::MIX_W-1:0]   mix_s;
  logic [CW-1:0]                lc_s, ld_s, hc_s, hd_s, coef, decay;
  logic [ssbm_pkg::SHAPE_W-1:0] k_sel;
  logic signed [63:0]           lim64;
  logic                         mix_lo;
  logic signed [31:0]           a_cur, b_cur;
  logic [SB-1:0]                cur_mag;
  logic [CW-1:0]                mul_a;
  logic signed [MBW-1:0]        mul_b, mag_b;
  logic signed [PW-1:0]         prod_nxt;
  logic signed [PW:0]           sum;
  logic signed [31:0]           upd;
  logic [DW:0]                  trial;
  logic                         ge;
  logic signed [63:0]           q64, qs, clip64;
  logic signed [SB-1:0]         clipped;

  assign mix_s  = (mix_r > ssbm_pkg::MIX_ONE) ? ssbm_pkg::MIX_ONE : mix_r;
  assign lc_s   = (lc_r > ssbm_pkg::COEF_ONE) ? ssbm_pkg::COEF_ONE : lc_r;
  assign ld_s   = (ld_r > ssbm_pkg::COEF_ONE) ? ssbm_pkg::COEF_ONE : ld_r;
  assign hc_s   = (hc_r > ssbm_pkg::COEF_ONE) ? ssbm_pkg::COEF_ONE : hc_r;
  assign hd_s   = (hd_r > ssbm_pkg::COEF_ONE) ? ssbm_pkg::COEF_ONE : hd_r;
  assign lim64  = ($signed(64'(clamp_r)) > SMAX64) ? SMAX64 : $signed(64'(clamp_r));
  assign mix_lo = (mix_s < ssbm_pkg::MIX_HALF);

  assign coef  = cmd.sel ? hc_s : lc_s;
  assign decay = cmd.sel ? hd_s : ld_s;
  assign a_cur = cmd.sel ? band1_r : band0_r;
  assign b_cur = cmd.sel ? low1_r : low0_r;
  assign k_sel = cmd.sel ? k2_r : k1_r;

  assign cur_mag = cur_r[SB-1] ? SB'(-cur_r) : SB'(cur_r);
  assign mag_b   = $signed(MBW'(cur_mag));

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      ssbm_pkg::P_K_MAG: begin
        mul_a = CW'(k_sel);
        mul_b = mag_b;
      end
      ssbm_pkg::P_DEN: begin
        mul_a = CW'(k_sel) + ssbm_pkg::SHAPE_ONE;
        mul_b = mag_b;
      end
      ssbm_pkg::P_SEC_MA: begin
        mul_a = decay;
        mul_b = MBW'(a_cur);
      end
      ssbm_pkg::P_SEC_MB: begin
        mul_a = coef;
        mul_b = MBW'(cur_r) - MBW'(b_cur);
      end
      ssbm_pkg::P_SEC_MC: begin
        mul_a = decay;
        mul_b = MBW'(b_cur);
      end
      ssbm_pkg::P_SEC_MD: begin
        mul_a = coef;
        mul_b = MBW'(a_cur);
      end
      ssbm_pkg::P_DC_M: begin
        mul_a = CW'(ssbm_pkg::DC_POLE);
        mul_b = MBW'(dc_out_r);
      end
      ssbm_pkg::P_MIX_M: begin
        mul_a = mix_lo ? CW'(mix_s) : CW'(ssbm_pkg::MIX_ONE - mix_s);
        mul_b = mix_lo ? MBW'(cur_r) : MBW'(dry_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PW'($signed({1'b0, mul_a})) * PW'(mul_b);

  // Integrator update: floor((acc + prod) / 2^24), saturated to 32 bits
  assign sum = (PW+1)'(acc_r) + (PW+1)'(prod_r);
  assign upd = sat32(64'(sum >>> 24));

  // Restoring divide, one quotient bit per step
  assign trial = {rem_r, quo_r[QW-1]};
  assign ge    = (trial >= {1'b0, den_r});

  // Clipper result: sign restore, saturate, then clamp on the first clipper
  assign q64 = $signed(64'(quo_r));
  assign qs  = cur_r[SB-1] ? -q64 : q64;
  assign clipped = sat_s(qs);
  always_comb begin
    clip64 = 64'(clipped);
    if (!cmd.sel) begin
      if (clip64 > lim64) begin
        clip64 = lim64;
      end else if (clip64 < -lim64) begin
        clip64 = -lim64;
      end
    end
  end

  // Configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r    <= ssbm_pkg::MIX_RESET;
      lc_r     <= ssbm_pkg::LOW_COEF_RESET;
      ld_r     <= ssbm_pkg::LOW_DECAY_RESET;
      hc_r     <= ssbm_pkg::HIGH_COEF_RESET;
      hd_r     <= ssbm_pkg::HIGH_DECAY_RESET;
      k1_r     <= ssbm_pkg::PRE_SHAPE_RESET;
      k2_r     <= ssbm_pkg::POST_SHAPE_RESET;
      clamp_r  <= ssbm_pkg::CLAMP_RESET;
      band0_r  <= '0;
      low0_r   <= '0;
      band1_r  <= '0;
      low1_r   <= '0;
      dc_in_r  <= '0;
      dc_out_r <= '0;
    end else begin
      if (cfg_we) begin
        case (ssbm_pkg::cfg_idx_t'(cfg_index))
          ssbm_pkg::CFG_MIX:        mix_r   <= cfg_data[ssbm_pkg::MIX_W-1:0];
          ssbm_pkg::CFG_LOW_COEF:   lc_r    <= cfg_data[CW-1:0];
          ssbm_pkg::CFG_LOW_DECAY:  ld_r    <= cfg_data[CW-1:0];
          ssbm_pkg::CFG_HIGH_COEF:  hc_r    <= cfg_data[CW-1:0];
          ssbm_pkg::CFG_HIGH_DECAY: hd_r    <= cfg_data[CW-1:0];
          ssbm_pkg::CFG_PRE_SHAPE:  k1_r    <= cfg_data[ssbm_pkg::SHAPE_W-1:0];
          ssbm_pkg::CFG_POST_SHAPE: k2_r    <= cfg_data[ssbm_pkg::SHAPE_W-1:0];
          ssbm_pkg::CFG_CLAMP:      clamp_r <= cfg_data[ssbm_pkg::CLAMP_W-1:0];
          default: ;
        endcase
      end
      case (cmd.step)
        ssbm_pkg::P_SEC_UA: begin
          if (cmd.sel) band1_r <= upd;
          else         band0_r <= upd;
        end
        ssbm_pkg::P_SEC_UB: begin
          if (cmd.sel) low1_r <= upd;
          else         low0_r <= upd;
        end
        ssbm_pkg::P_DC_END: begin
          dc_in_r  <= cur_r;
          dc_out_r <= sat_s(64'(cur_r) - 64'(dc_in_r) + 64'(prod_r >>> 15));
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dry_r <= in_sample;
      cur_r <= in_sample;
    end else begin
      case (cmd.step)
        ssbm_pkg::P_K_MAG: prod_r <= prod_nxt;
        ssbm_pkg::P_DEN: begin
          den_r  <= DW'(prod_r >>> (F - 8)) + DEN_ONE;
          prod_r <= prod_nxt;
        end
        ssbm_pkg::P_DIV_LOAD: begin
          rem_r <= DW'(prod_r >>> (QW - 8));
          quo_r <= QW'({prod_r, 8'd0});
        end
        ssbm_pkg::P_DIV: begin
          rem_r <= ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
          quo_r <= {quo_r[QW-2:0], ge};
        end
        ssbm_pkg::P_CLIP_END: cur_r <= clip64[SB-1:0];
        ssbm_pkg::P_SEC_MA, ssbm_pkg::P_SEC_MC: prod_r <= prod_nxt;
        ssbm_pkg::P_SEC_MB, ssbm_pkg::P_SEC_MD: begin
          acc_r  <= prod_r;
          prod_r <= prod_nxt;
        end
        ssbm_pkg::P_SEC_UB: begin
          if (cmd.sel) cur_r <= sat_s(64'(cur_r) - 64'(upd));
          else         cur_r <= sat_s(64'(upd));
        end
        ssbm_pkg::P_DC_M:  prod_r <= prod_nxt;
        ssbm_pkg::P_DC_END: begin
          cur_r <= sat_s(64'(cur_r) - 64'(dc_in_r) + 64'(prod_r >>> 15));
        end
        ssbm_pkg::P_MIX_M: prod_r <= prod_nxt;
        ssbm_pkg::P_MIX_END: begin
          if (cmd.out_load) begin
            out_r <= sat_s(64'(mix_lo ? dry_r : cur_r) + 64'(prod_r >>> 15));
          end
        end
        default: ;
      endcase
    end
  end

  assign out_sample = out_r;

endmodule

[hw/rtl/saturating_svf_bandpass_mixer_top.sv]
`timescale 1ns / 1ps

// A new word is accepted only once the previous one has been loaded into the result register;
//   the two clipper divides, one quotient bit a cycle on a shared restoring divider,
//   take most of the time spent on each word.
// All products go through one 25x34 multiplier, one product per cycle.
// Reset (rst_n low, synchronous): registers return to defaults, filter and
//   DC blocker state clear, out valid drops.
module saturating_svf_bandpass_mixer_top #(
  parameter int SAMPLE_BITS = ssbm_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ssbm_in_if.sink     in_ch,
  ssbm_out_if.source  out_ch,
  ssbm_cfg_if.sink    cfg_ch
);

  ssbm_pkg::cmd_t cmd;

  // Register writes are always taken; the user must write them only while the block is idle (not enforced here).
  assign cfg_ch.ready = 1'b1;

  // Sequencer: steps the datapath through clipper, two filter sections,
  // second clipper, DC blocker and the dry/wet crossfade.
  ssbm_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // Arithmetic, configuration registers, filter state and result register.
  ssbm_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_we     (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .in_sample  (in_ch.sample_in),
    .out_sample (out_ch.sample_out)
  );

endmodule

[hw/rtl/ssbm_checker.sv]
`timescale 1ns / 1ps

module ssbm_checker #(
  parameter int SAMPLE_BITS = ssbm_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_data
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared right after accept");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out word changed while stalled");

endmodule

bind saturating_svf_bandpass_mixer_top ssbm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_ssbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.sample_out)
);
